/* src/rbs_pkg.sv */
// Shared types and constants of the radial blend select core.
package rbs_pkg;

  // configuration register width and layout
  localparam int unsigned CFG_W = 32;
  localparam logic [CFG_W-1:0] RADIUS_SQ_RST = 32'd65536;
  localparam logic [CFG_W-1:0] BAND_SQ_RST = 32'd3277;

  // register index as decoded from the byte address
  localparam logic REG_RADIUS_SQ = 1'b0;
  localparam logic REG_BAND_SQ = 1'b1;

  // band compare runs at least this wide before the sign bit
  localparam int unsigned CMP_MIN_W = 33;

  // distance into the band and the divisor 2*T2 both fit here
  localparam int unsigned DIV_W = CFG_W + 1;

  // blend weight, unsigned Q0.16 with room for 1.0
  localparam int unsigned W_FRAC = 16;
  localparam int unsigned W_BITS = W_FRAC + 1;
  localparam logic [W_BITS-1:0] W_HALF = 17'd32768;

  // stage counts of the front and back sections
  localparam int unsigned RAD_STAGES = 3;
  localparam int unsigned BLEND_STAGES = 3;

  typedef enum logic [1:0] {
    REGION_OUTSIDE = 2'd0,
    REGION_INSIDE  = 2'd1,
    REGION_BAND    = 2'd2
  } region_e;

  typedef struct packed {
    logic [CFG_W-1:0] radius_sq;
    logic [CFG_W-1:0] band_sq;
  } cfg_t;

endpackage

/* src/radial_blend_select_core.sv */
// Pipeline: 3 front, 17 divider and 3 back stages between request accept and result.
// Throughput: one request per cycle while no stall holds the pipeline; the 17-stage quotient pipeline sets the depth.
// Stalls hold only full stages, so empty slots keep filling while a result waits.
// Reset clears all valid bits and loads radius_squared = 1.0 and band_squared = 0.05.
// Top level of the radial blend select core: config registers and stage wiring.
module radial_blend_select_core #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic signed [VALUE_BITS-1:0] inner_value_i,
  input  logic signed [VALUE_BITS-1:0] outer_value_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0] blended_o,
  output logic [1:0]                   region_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned SIDE_W = $bits(rbs_pkg::region_e) + 2 * VALUE_BITS;

  // configuration registers
  rbs_pkg::cfg_t cfg_q;
  logic          cfg_wr;
  logic          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius_sq <= rbs_pkg::RADIUS_SQ_RST;
      cfg_q.band_sq   <= rbs_pkg::BAND_SQ_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rbs_pkg::REG_RADIUS_SQ: cfg_q.radius_sq <= pwdata;
        rbs_pkg::REG_BAND_SQ:   cfg_q.band_sq   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rbs_pkg::REG_RADIUS_SQ: prdata = cfg_q.radius_sq;
      rbs_pkg::REG_BAND_SQ:   prdata = cfg_q.band_sq;
      default:                prdata = '0;
    endcase
  end

  // front section
  logic                        rad_valid, rad_hold;
  rbs_pkg::region_e            rad_region;
  logic [rbs_pkg::DIV_W-1:0]   rad_dist;
  logic signed [VALUE_BITS-1:0] rad_inner, rad_outer;

  rbs_radius #(
    .COORD_BITS (COORD_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_radius (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .hold_o   (in_stall_o),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .pos_z_i  (pos_z_i),
    .inner_i  (inner_value_i),
    .outer_i  (outer_value_i),
    .cfg_i    (cfg_q),
    .valid_o  (rad_valid),
    .hold_i   (rad_hold),
    .region_o (rad_region),
    .dist_o   (rad_dist),
    .inner_o  (rad_inner),
    .outer_o  (rad_outer)
  );

  // weight divider, region and values ride along as sideband
  logic                         div_valid, div_hold;
  logic [rbs_pkg::W_BITS-1:0]   div_weight;
  logic [SIDE_W-1:0]            div_side_in, div_side;
  rbs_pkg::region_e             div_region;
  logic signed [VALUE_BITS-1:0] div_inner, div_outer;

  assign div_side_in = {rad_region, rad_inner, rad_outer};

  rbs_divider #(
    .SIDE_W (SIDE_W)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rad_valid),
    .hold_o    (rad_hold),
    .dist_i    (rad_dist),
    .side_i    (div_side_in),
    .band_sq_i (cfg_q.band_sq),
    .valid_o   (div_valid),
    .hold_i    (div_hold),
    .weight_o  (div_weight),
    .side_o    (div_side)
  );

  assign div_region = rbs_pkg::region_e'(div_side[SIDE_W-1 -: $bits(rbs_pkg::region_e)]);
  assign div_inner  = $signed(div_side[2*VALUE_BITS-1 -: VALUE_BITS]);
  assign div_outer  = $signed(div_side[VALUE_BITS-1:0]);

  // back section, its last stage is the output register
  rbs_pkg::region_e out_region;

  rbs_blend #(
    .VALUE_BITS (VALUE_BITS)
  ) u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (div_valid),
    .hold_o    (div_hold),
    .weight_i  (div_weight),
    .region_i  (div_region),
    .inner_i   (div_inner),
    .outer_i   (div_outer),
    .valid_o   (out_valid_o),
    .hold_i    (out_stall_i),
    .blended_o (blended_o),
    .region_o  (out_region)
  );

  assign region_o = out_region;

`ifndef SYNTHESIS
  // input side only stalls when every stage is full and the result is stalled
  a_stall_needs_full_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && rad_valid && div_valid))
    else $error("request stalled while pipeline not blocked");

  // a delivered result always frees the front stage
  a_drain_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |-> !in_stall_o)
    else $error("request stalled although result drained");

  // register writes land in the addressed register
  a_radius_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (cfg_idx == rbs_pkg::REG_RADIUS_SQ)) |=>
      (cfg_q.radius_sq == $past(pwdata)))
    else $error("radius_squared write lost");

  a_band_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (cfg_idx == rbs_pkg::REG_BAND_SQ)) |=>
      (cfg_q.band_sq == $past(pwdata)))
    else $error("band_squared write lost");
`endif

endmodule

/* src/rbs_radius.sv */
// Front section: squares, radius sum and band classification (three stages).
module rbs_radius #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          hold_o,
  input  logic signed [COORD_BITS-1:0]  pos_x_i,
  input  logic signed [COORD_BITS-1:0]  pos_y_i,
  input  logic signed [COORD_BITS-1:0]  pos_z_i,
  input  logic signed [VALUE_BITS-1:0]  inner_i,
  input  logic signed [VALUE_BITS-1:0]  outer_i,
  input  rbs_pkg::cfg_t                 cfg_i,
  output logic                          valid_o,
  input  logic                          hold_i,
  output rbs_pkg::region_e              region_o,
  output logic [rbs_pkg::DIV_W-1:0]     dist_o,
  output logic signed [VALUE_BITS-1:0]  inner_o,
  output logic signed [VALUE_BITS-1:0]  outer_o
);

  localparam int unsigned SQ_W = 2 * COORD_BITS;
  localparam int unsigned CMP_W =
    ((SQ_W > rbs_pkg::CMP_MIN_W) ? SQ_W : rbs_pkg::CMP_MIN_W) + 1;
  localparam int unsigned NST = rbs_pkg::RAD_STAGES;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] hold;

  // stall chain: a stage holds when it is full and the next one holds
  assign hold[NST-1] = vld_q[NST-1] & hold_i;
  assign hold[1]     = vld_q[1] & hold[2];
  assign hold[0]     = vld_q[0] & hold[1];
  assign hold_o      = hold[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (!hold[0]) vld_q[0] <= valid_i;
      if (!hold[1]) vld_q[1] <= vld_q[0];
      if (!hold[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 1: three squares
  logic signed [SQ_W-1:0] sqx_d, sqy_d, sqz_d;
  logic [SQ_W-1:0]        sqx_q, sqy_q, sqz_q;
  logic signed [VALUE_BITS-1:0] inner1_q, outer1_q;

  assign sqx_d = pos_x_i * pos_x_i;
  assign sqy_d = pos_y_i * pos_y_i;
  assign sqz_d = pos_z_i * pos_z_i;

  always_ff @(posedge clk_i) begin
    if (!hold[0]) begin
      sqx_q    <= $unsigned(sqx_d);
      sqy_q    <= $unsigned(sqy_d);
      sqz_q    <= $unsigned(sqz_d);
      inner1_q <= inner_i;
      outer1_q <= outer_i;
    end
  end

  // stage 2: r2 sum; three squares stay below 2^SQ_W
  logic [SQ_W-1:0] r2_d, r2_q;
  logic signed [VALUE_BITS-1:0] inner2_q, outer2_q;

  assign r2_d = sqx_q + sqy_q + sqz_q;

  always_ff @(posedge clk_i) begin
    if (!hold[1]) begin
      r2_q     <= r2_d;
      inner2_q <= inner1_q;
      outer2_q <= outer1_q;
    end
  end

  // stage 3: compare against R2 +/- T2 and take distance below upper edge
  logic signed [CMP_W-1:0] r2_ext, rad_ext, band_ext, hi_ext, lo_ext, dist_ext;
  rbs_pkg::region_e        region_d, region_q;
  logic [rbs_pkg::DIV_W-1:0] dist_q;
  logic signed [VALUE_BITS-1:0] inner3_q, outer3_q;

  assign r2_ext   = $signed({{(CMP_W - SQ_W){1'b0}}, r2_q});
  assign rad_ext  = $signed({{(CMP_W - rbs_pkg::CFG_W){1'b0}}, cfg_i.radius_sq});
  assign band_ext = $signed({{(CMP_W - rbs_pkg::CFG_W){1'b0}}, cfg_i.band_sq});
  assign hi_ext   = rad_ext + band_ext;
  assign lo_ext   = rad_ext - band_ext;
  assign dist_ext = hi_ext - r2_ext;

  always_comb begin
    if (r2_ext > hi_ext) begin
      region_d = rbs_pkg::REGION_OUTSIDE;
    end else if (r2_ext < lo_ext) begin
      region_d = rbs_pkg::REGION_INSIDE;
    end else begin
      region_d = rbs_pkg::REGION_BAND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold[2]) begin
      region_q <= region_d;
      dist_q   <= dist_ext[rbs_pkg::DIV_W-1:0];
      inner3_q <= inner2_q;
      outer3_q <= outer2_q;
    end
  end

  assign valid_o  = vld_q[NST-1];
  assign region_o = region_q;
  assign dist_o   = dist_q;
  assign inner_o  = inner3_q;
  assign outer_o  = outer3_q;

endmodule

/* src/rbs_divider.sv */
// Pipelined restoring divider: one quotient bit per stage, weight = dist*2^16/(2*T2).
module rbs_divider #(
  parameter int unsigned SIDE_W = 34
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              hold_o,
  input  logic [rbs_pkg::DIV_W-1:0]         dist_i,
  input  logic [SIDE_W-1:0]                 side_i,
  input  logic [rbs_pkg::CFG_W-1:0]         band_sq_i,
  output logic                              valid_o,
  input  logic                              hold_i,
  output logic [rbs_pkg::W_BITS-1:0]        weight_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int unsigned NST = rbs_pkg::W_BITS;
  localparam int unsigned DW  = rbs_pkg::DIV_W;

  logic [DW:0]               divisor;
  logic [NST-1:0]            vld_q;
  logic [NST-1:0]            hold;
  logic [DW-1:0]             rem_q [NST];
  logic [NST-1:0]            quo_q [NST];
  logic [SIDE_W-1:0]         side_q [NST];

  // divisor 2*T2, one bit wider for the shifted remainder compare
  assign divisor = {1'b0, band_sq_i, 1'b0};

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic            vin;
    logic            hnext;
    logic [DW-1:0]   rem_in;
    logic [NST-1:0]  quo_in;
    logic [SIDE_W-1:0] side_in;
    logic [DW:0]     shifted;
    logic [DW:0]     sub;
    logic            ge;

    if (k == 0) begin : g_first
      // first step decides the integer bit (weight of exactly one)
      assign vin     = valid_i;
      assign rem_in  = dist_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign shifted = {1'b0, rem_in};
    end else begin : g_next
      assign vin     = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
      assign shifted = {rem_in, 1'b0};
    end

    if (k == NST - 1) begin : g_last
      assign hnext = hold_i;
    end else begin : g_mid
      assign hnext = hold[k+1];
    end

    assign hold[k] = vld_q[k] & hnext;
    assign sub     = shifted - divisor;
    assign ge      = (shifted >= divisor);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (!hold[k]) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!hold[k]) begin
        rem_q[k]  <= ge ? sub[DW-1:0] : shifted[DW-1:0];
        quo_q[k]  <= {quo_in[NST-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign hold_o  = hold[0];
  assign valid_o = vld_q[NST-1];
  assign side_o  = side_q[NST-1];

  // a zero band holds only r2 == R2, which takes the middle weight
  assign weight_o = (band_sq_i == '0) ? rbs_pkg::W_HALF : quo_q[NST-1];

endmodule

/* src/rbs_blend.sv */
// Back section: weighted difference, product and final select (three stages).
module rbs_blend #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          hold_o,
  input  logic [rbs_pkg::W_BITS-1:0]    weight_i,
  input  rbs_pkg::region_e              region_i,
  input  logic signed [VALUE_BITS-1:0]  inner_i,
  input  logic signed [VALUE_BITS-1:0]  outer_i,
  output logic                          valid_o,
  input  logic                          hold_i,
  output logic signed [VALUE_BITS-1:0]  blended_o,
  output rbs_pkg::region_e              region_o
);

  localparam int unsigned NST    = rbs_pkg::BLEND_STAGES;
  localparam int unsigned DIFF_W = VALUE_BITS + 1;
  localparam int unsigned PROD_W = DIFF_W + rbs_pkg::W_BITS + 1;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] hold;

  assign hold[2] = vld_q[2] & hold_i;
  assign hold[1] = vld_q[1] & hold[2];
  assign hold[0] = vld_q[0] & hold[1];
  assign hold_o  = hold[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (!hold[0]) vld_q[0] <= valid_i;
      if (!hold[1]) vld_q[1] <= vld_q[0];
      if (!hold[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 1: inner - outer at one extra bit
  logic signed [DIFF_W-1:0]     diff_d, diff_q;
  logic [rbs_pkg::W_BITS-1:0]   w1_q;
  rbs_pkg::region_e             region1_q;
  logic signed [VALUE_BITS-1:0] inner1_q, outer1_q;

  assign diff_d = {inner_i[VALUE_BITS-1], inner_i} - {outer_i[VALUE_BITS-1], outer_i};

  always_ff @(posedge clk_i) begin
    if (!hold[0]) begin
      diff_q    <= diff_d;
      w1_q      <= weight_i;
      region1_q <= region_i;
      inner1_q  <= inner_i;
      outer1_q  <= outer_i;
    end
  end

  // stage 2: difference times weight
  logic signed [rbs_pkg::W_BITS:0] w_sgn;
  logic signed [PROD_W-1:0]        prod_d, prod_q;
  rbs_pkg::region_e                region2_q;
  logic signed [VALUE_BITS-1:0]    inner2_q, outer2_q;

  assign w_sgn  = $signed({1'b0, w1_q});
  assign prod_d = diff_q * w_sgn;

  always_ff @(posedge clk_i) begin
    if (!hold[1]) begin
      prod_q    <= prod_d;
      region2_q <= region1_q;
      inner2_q  <= inner1_q;
      outer2_q  <= outer1_q;
    end
  end

  // stage 3: floor of product / 2^16 added to outer, then region select
  logic signed [PROD_W-1:0]     scaled, outer_ext, mix;
  logic signed [VALUE_BITS-1:0] blended_d, blended_q;
  rbs_pkg::region_e             region3_q;

  assign scaled    = prod_q >>> rbs_pkg::W_FRAC;
  assign outer_ext = {{(PROD_W - VALUE_BITS){outer2_q[VALUE_BITS-1]}}, outer2_q};
  assign mix       = outer_ext + scaled;

  always_comb begin
    case (region2_q)
      rbs_pkg::REGION_OUTSIDE: blended_d = outer2_q;
      rbs_pkg::REGION_INSIDE:  blended_d = inner2_q;
      rbs_pkg::REGION_BAND:    blended_d = mix[VALUE_BITS-1:0];
      default:                 blended_d = outer2_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (!hold[2]) begin
      blended_q <= blended_d;
      region3_q <= region2_q;
    end
  end

  assign valid_o   = vld_q[2];
  assign blended_o = blended_q;
  assign region_o  = region3_q;

endmodule
